// ----- hdl/tlr_pkg.sv -----
// Shared types and constants for the timestamped record log ring.
// Used by the divider and the top level; depends on nothing.
package tlr_pkg;

    // Command codes carried on the opcode field.
    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_BYTE  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    // Byte that opens every record frame.
    localparam logic [7:0] MARK_BYTE = 8'h01;

    // Number of header bytes that follow the mark byte.
    localparam int HEADER_TAIL = 10;

    // One million is 2^6 times 15625; the stamp split divides by the odd factor
    // with a reciprocal multiply that is exact for any 30-bit partial dividend.
    localparam int          USEC_SHIFT  = 6;
    localparam logic [13:0] USEC_ODD    = 14'd15625;
    localparam logic [30:0] USEC_RECIP  = 31'd1125899907;
    localparam int          RECIP_SHIFT = 44;

    // Sequencer states, one-hot.
    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_IDLE  = 16'h0002,
        S_MUL   = 16'h0004,
        S_STAMP = 16'h0008,
        S_WR    = 16'h0010,
        S_ER10  = 16'h0020,
        S_ERRD  = 16'h0040,
        S_ERCHK = 16'h0080,
        S_RQRD  = 16'h0100,
        S_RQDAT = 16'h0200,
        S_RQDEC = 16'h0400,
        S_WRAP  = 16'h0800,
        S_CPRD  = 16'h1000,
        S_CPDAT = 16'h2000,
        S_DIV   = 16'h4000,
        S_SUM   = 16'h8000
    } state_t;

endpackage

// ----- hdl/tlr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module tlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when not enabled.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tlr_div.sv -----
// Reciprocal-multiply divider that splits a microsecond stamp into seconds
// and microseconds, one 16-bit quotient digit at a time. Depends on tlr_pkg.
module tlr_div
    import tlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    output logic [44:0] quot,
    output logic [19:0] rem,
    output logic        done
);

    logic [63:0] x_reg;
    logic [5:0]  low_reg;
    logic [13:0] r_reg;
    logic [63:0] q_reg;
    logic [60:0] prod_reg;
    logic [1:0]  cnt_reg;
    logic        phase_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [29:0] part;
    logic [15:0] digit;
    logic [29:0] back;

    // Partial dividend: running remainder followed by the next 16-bit digit.
    assign part  = {r_reg, x_reg[63:48]};
    assign digit = prod_reg[RECIP_SHIFT +: 16];
    assign back  = 30'(digit) * 30'(USEC_ODD);

    // Control: four digits, each a multiply phase then a subtract phase; done held until the next start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            phase_reg <= !phase_reg;
            if (phase_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: multiply by the reciprocal, then take the digit and remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= 64'(dividend >> USEC_SHIFT);
            low_reg <= dividend[5:0];
            r_reg   <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                prod_reg <= 61'(part) * 61'(USEC_RECIP);
            end
            else
            begin
                r_reg <= 14'(part - back);
                q_reg <= {q_reg[47:0], digit};
                x_reg <= {x_reg[47:0], 16'h0000};
            end
        end
    end

    assign quot = q_reg[44:0];
    assign rem  = {r_reg, low_reg};
    assign done = done_reg;

endmodule

// ----- hdl/timestamped_record_log_ring.sv -----
// Timestamped record log ring: input channel (opcode and fields) and output
// channel (copied text bytes, then one summary beat per read query).
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Begin record stores eleven header bytes, one per cycle unless an erase
// intervenes, after S_MUL and S_STAMP form the stamp; a message byte goes
// through S_WR. A store into a full ring first zeros the oldest record's mark,
// nine header bytes, then each byte up to the next mark (at most LOG_BYTES).
// A read query walks record headers a byte at a time through S_RQRD and
// S_RQDAT, takes each skipped record through S_RQDEC and S_WRAP (one ring
// length off per step), copies text through S_CPRD and S_CPDAT, and waits for
// the stamp divider, which starts as soon as the record is found.
// The block takes one command at a time; in_stall is high until it is done.
// Reset and the clear command sweep the store to zero, one byte per cycle,
// over all LOG_BYTES bytes, during which no command is taken.
// A single output register holds each result beat; while a beat waits and
// out_stall is high, the next beat waits and the held beat stays unchanged.
module timestamped_record_log_ring
    import tlr_pkg::*;
#(
    parameter int LOG_BYTES  = 1024,
    parameter int LINE_BYTES = 128,
    parameter int MAX_COPY   = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [52:0] uptime_ms,
    input  logic [6:0]  msg_length,
    input  logic [7:0]  msg_byte,
    input  logic [63:0] from_us,
    input  logic [6:0]  dest_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_kind,
    output logic [7:0]  out_byte,
    output logic [5:0]  copied_count,
    output logic        found,
    output logic [44:0] msg_sec,
    output logic [19:0] msg_usec,
    output logic        last
);

    localparam int AW = $clog2(LOG_BYTES);
    localparam logic [AW:0]   LOG_CNT   = (AW+1)'(LOG_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(LOG_BYTES - 1);
    localparam logic [16:0]   LOG_SUM   = 17'(LOG_BYTES);

    state_t state_reg, state_next;

    logic [AW-1:0] wpos_reg, wpos_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic          holds_reg, holds_next;
    logic [63:0]   last_clk_reg, last_clk_next;
    logic [63:0]   last_given_reg, last_given_next;
    logic [6:0]    pending_reg, pending_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic [3:0]    idx_reg, idx_next;
    logic          single_reg, single_next;
    logic          noerase_reg, noerase_next;

    logic [52:0]   ms_reg, ms_next;
    logic [6:0]    len_reg, len_next;
    logic [7:0]    byte_reg, byte_next;
    logic [63:0]   from_reg, from_next;
    logic [6:0]    dlen_reg, dlen_next;
    logic [63:0]   prod_reg, prod_next;
    logic [63:0]   stamp_reg, stamp_next;

    logic [AW-1:0] p_reg, p_next;
    logic [AW:0]   iter_reg, iter_next;
    logic [63:0]   ts_reg, ts_next;
    logic [15:0]   mlen_reg, mlen_next;
    logic [16:0]   sum_reg, sum_next;
    logic [5:0]    lim_reg, lim_next;
    logic [5:0]    n_reg, n_next;
    logic          found_reg, found_next;

    logic          ov_reg, ov_next;
    logic          ok_reg, ok_next;
    logic [7:0]    ob_reg, ob_next;
    logic [5:0]    oc_reg, oc_next;
    logic          of_reg, of_next;
    logic [44:0]   os_reg, os_next;
    logic [19:0]   ou_reg, ou_next;
    logic          ol_reg, ol_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic          div_start, div_done;
    logic [44:0]   div_quot;
    logic [19:0]   div_rem;

    logic          slot_free;
    logic [7:0]    hdr_byte;
    logic [15:0]   lim_a, lim_b;
    logic [AW-1:0] wrap_pos;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        return (p == LAST_ADDR) ? '0 : p + AW'(1);
    endfunction

    // Byte store and its registered read port.
    tlr_ram #(
        .WIDTH (8),
        .DEPTH (LOG_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Stamp to seconds and microseconds.
    tlr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ts_reg),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    assign slot_free = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // Header byte for the current store step.
    always_comb
    begin
        case (idx_reg)
            4'd0:    hdr_byte = MARK_BYTE;
            4'd9:    hdr_byte = {1'b0, len_reg};
            4'd10:   hdr_byte = 8'h00;
            default: hdr_byte = 8'(stamp_reg >> (8 * (32'(idx_reg) - 1)));
        endcase
    end

    // Copy limit: smallest of destination room, stored length and copy cap.
    assign lim_a    = 16'(dlen_reg - 7'd1);
    assign lim_b    = (mlen_reg < lim_a) ? mlen_reg : lim_a;
    assign wrap_pos = sum_reg[AW-1:0];

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        wpos_next       = wpos_reg;
        oldest_next     = oldest_reg;
        holds_next      = holds_reg;
        last_clk_next   = last_clk_reg;
        last_given_next = last_given_reg;
        pending_next    = pending_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        single_next     = single_reg;
        noerase_next    = noerase_reg;
        ms_next         = ms_reg;
        len_next        = len_reg;
        byte_next       = byte_reg;
        from_next       = from_reg;
        dlen_next       = dlen_reg;
        prod_next       = prod_reg;
        stamp_next      = stamp_reg;
        p_next          = p_reg;
        iter_next       = iter_reg;
        ts_next         = ts_reg;
        mlen_next       = mlen_reg;
        sum_next        = sum_reg;
        lim_next        = lim_reg;
        n_next          = n_reg;
        found_next      = found_reg;
        ov_next         = ov_reg && out_stall;
        ok_next         = ok_reg;
        ob_next         = ob_reg;
        oc_next         = oc_reg;
        of_next         = of_reg;
        os_next         = os_reg;
        ou_next         = ou_reg;
        ol_next         = ol_reg;
        ram_we          = 1'b0;
        ram_waddr       = wpos_reg;
        ram_wdata       = 8'h00;
        ram_re          = 1'b0;
        ram_raddr       = p_reg;
        div_start       = 1'b0;

        case (state_reg)
            // Zero sweep after reset or clear.
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                cnt_next  = cnt_reg + (AW+1)'(1);
                if (cnt_reg[AW-1:0] == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end

            // Take a command.
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ms_next   = uptime_ms;
                    byte_next = msg_byte;
                    from_next = from_us;
                    dlen_next = dest_len;
                    len_next  = (int'(msg_length) > LINE_BYTES) ? 7'(LINE_BYTES) : msg_length;
                    case (opcode_t'(opcode))
                        OP_BEGIN:
                        begin
                            state_next = S_MUL;
                        end
                        OP_BYTE:
                        begin
                            if (pending_reg != 7'd0)
                            begin
                                pending_next = pending_reg - 7'd1;
                                single_next  = 1'b1;
                                state_next   = S_WR;
                            end
                        end
                        OP_READ:
                        begin
                            n_next     = '0;
                            found_next = 1'b0;
                            p_next     = oldest_reg;
                            iter_next  = '0;
                            idx_next   = '0;
                            state_next = (dest_len < 7'd2) ? S_SUM : S_RQRD;
                        end
                        OP_CLEAR:
                        begin
                            wpos_next       = '0;
                            oldest_next     = '0;
                            holds_next      = 1'b0;
                            last_clk_next   = '0;
                            last_given_next = '0;
                            pending_next    = '0;
                            cnt_next        = '0;
                            state_next      = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Milliseconds times 1000 as 1024 - 16 - 8.
            S_MUL:
            begin
                prod_next  = ({11'b0, ms_reg} << 10) - ({11'b0, ms_reg} << 4)
                           - ({11'b0, ms_reg} << 3);
                state_next = S_STAMP;
            end

            // A repeated clock value gets the last stamp plus one.
            S_STAMP:
            begin
                if (prod_reg == last_clk_reg)
                begin
                    last_given_next = last_given_reg + 64'd1;
                    stamp_next      = last_given_reg + 64'd1;
                end
                else
                begin
                    last_clk_next   = prod_reg;
                    last_given_next = prod_reg;
                    stamp_next      = prod_reg;
                end
                pending_next = len_reg;
                idx_next     = '0;
                single_next  = 1'b0;
                state_next   = S_WR;
            end

            // Store one byte, erasing the oldest record first when full.
            S_WR:
            begin
                if (holds_reg && (oldest_reg == wpos_reg) && !noerase_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_ER10;
                end
                else
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = wpos_reg;
                    ram_wdata    = single_reg ? byte_reg : hdr_byte;
                    wpos_next    = next_pos(wpos_reg);
                    holds_next   = 1'b1;
                    noerase_next = 1'b0;
                    idx_next     = idx_reg + 4'd1;
                    if (single_reg || (idx_reg == 4'(HEADER_TAIL)))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Zero the oldest record's mark and the first nine header bytes.
            S_ER10:
            begin
                ram_we      = 1'b1;
                ram_waddr   = oldest_reg;
                oldest_next = next_pos(oldest_reg);
                cnt_next    = cnt_reg + (AW+1)'(1);
                if (cnt_reg == (AW+1)'(HEADER_TAIL - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ERRD;
                end
            end

            // Zero text bytes up to the next mark, bounded by the store size.
            S_ERRD:
            begin
                if (cnt_reg == LOG_CNT)
                begin
                    noerase_next = 1'b1;
                    state_next   = S_WR;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = oldest_reg;
                    state_next = S_ERCHK;
                end
            end

            S_ERCHK:
            begin
                if (ram_rdata == MARK_BYTE)
                begin
                    noerase_next = 1'b1;
                    state_next   = S_WR;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = oldest_reg;
                    oldest_next = next_pos(oldest_reg);
                    cnt_next    = cnt_reg + (AW+1)'(1);
                    state_next  = S_ERRD;
                end
            end

            // Fetch one header byte of the record at p.
            S_RQRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = p_reg;
                p_next     = next_pos(p_reg);
                state_next = S_RQDAT;
            end

            S_RQDAT:
            begin
                idx_next   = idx_reg + 4'd1;
                state_next = S_RQRD;
                case (idx_reg)
                    4'd0:
                    begin
                        if (ram_rdata != MARK_BYTE)
                        begin
                            state_next = S_SUM;
                        end
                    end
                    4'd9:
                    begin
                        mlen_next[7:0] = ram_rdata;
                    end
                    4'd10:
                    begin
                        mlen_next[15:8] = ram_rdata;
                        state_next      = S_RQDEC;
                    end
                    default:
                    begin
                        ts_next = {ram_rdata, ts_reg[63:8]};
                    end
                endcase
            end

            // Take this record, or skip over its text.
            S_RQDEC:
            begin
                if (ts_reg > from_reg)
                begin
                    found_next = 1'b1;
                    div_start  = 1'b1;
                    lim_next   = (lim_b > 16'(MAX_COPY)) ? 6'(MAX_COPY) : lim_b[5:0];
                    state_next = S_CPRD;
                end
                else
                begin
                    sum_next   = 17'(p_reg) + 17'(mlen_reg);
                    iter_next  = iter_reg + (AW+1)'(1);
                    state_next = S_WRAP;
                end
            end

            // Reduce the skip target into the ring, one subtraction a cycle.
            S_WRAP:
            begin
                if (sum_reg >= LOG_SUM)
                begin
                    sum_next = sum_reg - LOG_SUM;
                end
                else
                begin
                    p_next   = wrap_pos;
                    idx_next = '0;
                    if ((wrap_pos != oldest_reg) && (iter_reg < LOG_CNT))
                    begin
                        state_next = S_RQRD;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end

            // Copy text bytes out.
            S_CPRD:
            begin
                if (n_reg >= lim_reg)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = p_reg;
                    p_next     = next_pos(p_reg);
                    state_next = S_CPDAT;
                end
            end

            S_CPDAT:
            begin
                if (ram_rdata == 8'h00)
                begin
                    state_next = S_DIV;
                end
                else if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ok_next    = 1'b0;
                    ob_next    = ram_rdata;
                    oc_next    = '0;
                    of_next    = 1'b0;
                    os_next    = '0;
                    ou_next    = '0;
                    ol_next    = 1'b0;
                    n_next     = n_reg + 6'd1;
                    state_next = S_CPRD;
                end
            end

            // Wait for the stamp split.
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end

            // Summary beat.
            S_SUM:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ok_next    = 1'b1;
                    ob_next    = 8'h00;
                    oc_next    = n_reg;
                    of_next    = found_reg;
                    os_next    = found_reg ? div_quot : '0;
                    ou_next    = found_reg ? div_rem : '0;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            wpos_reg       <= '0;
            oldest_reg     <= '0;
            holds_reg      <= 1'b0;
            last_clk_reg   <= '0;
            last_given_reg <= '0;
            pending_reg    <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            single_reg     <= 1'b0;
            noerase_reg    <= 1'b0;
            n_reg          <= '0;
            found_reg      <= 1'b0;
            iter_reg       <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wpos_reg       <= wpos_next;
            oldest_reg     <= oldest_next;
            holds_reg      <= holds_next;
            last_clk_reg   <= last_clk_next;
            last_given_reg <= last_given_next;
            pending_reg    <= pending_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            single_reg     <= single_next;
            noerase_reg    <= noerase_next;
            n_reg          <= n_next;
            found_reg      <= found_next;
            iter_reg       <= iter_next;
            ov_reg         <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ms_reg    <= ms_next;
        len_reg   <= len_next;
        byte_reg  <= byte_next;
        from_reg  <= from_next;
        dlen_reg  <= dlen_next;
        prod_reg  <= prod_next;
        stamp_reg <= stamp_next;
        p_reg     <= p_next;
        ts_reg    <= ts_next;
        mlen_reg  <= mlen_next;
        sum_reg   <= sum_next;
        lim_reg   <= lim_next;
        ok_reg    <= ok_next;
        ob_reg    <= ob_next;
        oc_reg    <= oc_next;
        of_reg    <= of_next;
        os_reg    <= os_next;
        ou_reg    <= ou_next;
        ol_reg    <= ol_next;
    end

    assign out_valid    = ov_reg;
    assign out_kind     = ok_reg;
    assign out_byte     = ob_reg;
    assign copied_count = oc_reg;
    assign found        = of_reg;
    assign msg_sec      = os_reg;
    assign msg_usec     = ou_reg;
    assign last         = ol_reg;

endmodule
